>>> sv/xcs_pkg.sv
// ----------------------------------------------------------------------------
// xcs_pkg
// Shared types, codes and constants for the XMODEM checksum sender.
// ----------------------------------------------------------------------------
package xcs_pkg;

	// packet geometry
	localparam int PACKET_BYTES = 128;
	localparam int FILL_W       = $clog2(PACKET_BYTES + 1);
	localparam int MAX_RESULTS  = 4;
	localparam int RES_IDX_W    = $clog2(MAX_RESULTS);
	localparam int QUEUE_DEPTH  = 2;

	// link characters
	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_NAK = 8'h15;

	// input operation codes
	localparam logic [1:0] OP_DATA = 2'd0;
	localparam logic [1:0] OP_EOF  = 2'd1;
	localparam logic [1:0] OP_LINK = 2'd2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_REFUSED  = 2'd1,
		ST_ABORTED  = 2'd2,
		ST_FINISHED = 2'd3
	} status_t;

	// one run of identical link bytes
	typedef struct packed {
		logic       send;
		logic [7:0] tx_byte;
		logic [7:0] run_length;
	} res_t;

	// everything one accepted word produces, handed from front to back
	typedef struct packed {
		res_t [MAX_RESULTS-1:0] res;
		logic [RES_IDX_W-1:0]   last_idx;
		status_t                status;
		logic [7:0]             block_number;
	} job_t;

	function automatic res_t mk_res(input logic [7:0] b, input logic [7:0] run);
		res_t r;
		r.send       = 1'b1;
		r.tx_byte    = b;
		r.run_length = run;
		return r;
	endfunction

endpackage

>>> sv/xcs_front.sv
// ----------------------------------------------------------------------------
// xcs_front
// Protocol state machine: takes one input word a cycle while the queue is not
// full, updates the session state and packs the resulting link runs into a job for the back end.
// ----------------------------------------------------------------------------
module xcs_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  logic [1:0]    op,
	input  logic [7:0]    value,
	output xcs_pkg::job_t job,
	output logic          job_push,
	input  logic          q_full
);
	import xcs_pkg::*;

	typedef enum logic [2:0] {
		PH_WAIT_NAK,
		PH_FILL,
		PH_WAIT_ACK,
		PH_WAIT_EOT_ACK,
		PH_DONE,
		PH_ABORTED
	} phase_t;

	localparam logic [FILL_W-1:0] PKT_LEN = FILL_W'(PACKET_BYTES);

	phase_t              phase_q, phase_d;
	logic [7:0]          block_q, block_d;
	logic [FILL_W-1:0]   fill_q, fill_d, fill_inc, pad_len;
	logic [7:0]          sum_q, sum_d, sum_inc;
	logic                eot_q, eot_d;
	status_t             status_c;
	res_t [MAX_RESULTS-1:0] res_c;
	logic [RES_IDX_W:0]  n;

	assign item_stall = q_full;
	assign job_push   = item_valid && !q_full;
	assign fill_inc   = fill_q + 1'b1;
	assign pad_len    = PKT_LEN - fill_q;
	assign sum_inc    = sum_q + value;

	always_comb begin
		phase_d  = phase_q;
		block_d  = block_q;
		fill_d   = fill_q;
		sum_d    = sum_q;
		eot_d    = eot_q;
		status_c = ST_OK;
		res_c    = '0;
		n        = '0;
		unique case (phase_q)
			PH_WAIT_NAK: begin
				if (op == OP_LINK) begin
					if (value == CH_NAK)
						phase_d = PH_FILL;
				end else begin
					status_c = ST_REFUSED;
				end
			end
			PH_FILL: begin
				if (op == OP_DATA) begin
					if (fill_q == '0) begin
						res_c[n[RES_IDX_W-1:0]] = mk_res(CH_SOH, 8'd1);
						n = n + 1'b1;
						res_c[n[RES_IDX_W-1:0]] = mk_res(block_q, 8'd1);
						n = n + 1'b1;
						res_c[n[RES_IDX_W-1:0]] = mk_res(8'd255 - block_q, 8'd1);
						n = n + 1'b1;
					end
					res_c[n[RES_IDX_W-1:0]] = mk_res(value, 8'd1);
					n = n + 1'b1;
					sum_d  = sum_inc;
					fill_d = fill_inc;
					if (fill_inc == PKT_LEN) begin
						res_c[n[RES_IDX_W-1:0]] = mk_res(sum_inc, 8'd1);
						n = n + 1'b1;
						phase_d = PH_WAIT_ACK;
					end
				end else if (op == OP_EOF) begin
					if (fill_q == '0) begin
						res_c[0] = mk_res(CH_EOT, 8'd1);
						n        = (RES_IDX_W+1)'(1);
						phase_d  = PH_WAIT_EOT_ACK;
					end else begin
						res_c[0] = mk_res(8'd0, 8'(pad_len));
						res_c[1] = mk_res(sum_q, 8'd1);
						n        = (RES_IDX_W+1)'(2);
						eot_d    = 1'b1;
						phase_d  = PH_WAIT_ACK;
					end
				end else begin
					status_c = ST_REFUSED;
				end
			end
			PH_WAIT_ACK: begin
				if (op == OP_LINK) begin
					if (value == CH_ACK) begin
						block_d = block_q + 8'd1;
						fill_d  = '0;
						sum_d   = '0;
						if (eot_q) begin
							res_c[0] = mk_res(CH_EOT, 8'd1);
							n        = (RES_IDX_W+1)'(1);
							phase_d  = PH_WAIT_EOT_ACK;
						end else begin
							phase_d = PH_FILL;
						end
					end else begin
						status_c = ST_ABORTED;
						phase_d  = PH_ABORTED;
					end
				end else begin
					status_c = ST_REFUSED;
				end
			end
			PH_WAIT_EOT_ACK: begin
				if (op == OP_LINK) begin
					if (value == CH_ACK) begin
						status_c = ST_FINISHED;
						phase_d  = PH_DONE;
					end else begin
						res_c[0] = mk_res(CH_EOT, 8'd1);
						n        = (RES_IDX_W+1)'(1);
					end
				end else begin
					status_c = ST_REFUSED;
				end
			end
			default: status_c = ST_REFUSED;
		endcase
	end

	// a job with no runs still delivers one bare result
	always_comb begin
		job.res          = res_c;
		job.status       = status_c;
		job.block_number = block_d;
		if (n == '0)
			job.last_idx = '0;
		else
			job.last_idx = n[RES_IDX_W-1:0] - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_NAK;
			block_q <= 8'd1;
			fill_q  <= '0;
			sum_q   <= '0;
			eot_q   <= 1'b0;
		end else if (job_push) begin
			phase_q <= phase_d;
			block_q <= block_d;
			fill_q  <= fill_d;
			sum_q   <= sum_d;
			eot_q   <= eot_d;
		end
	end

endmodule

>>> sv/xcs_queue.sv
// ----------------------------------------------------------------------------
// xcs_queue
// Short job queue between the protocol front end and the result sequencer.
// ----------------------------------------------------------------------------
module xcs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  xcs_pkg::job_t wr_data,
	input  logic          pop,
	output xcs_pkg::job_t rd_data,
	output logic          empty,
	output logic          full
);
	import xcs_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> sv/xcs_back.sv
// ----------------------------------------------------------------------------
// xcs_back
// Result sequencer: walks the runs of the head job, one result word a
// cycle while result_stall is low, into a registered output stage.
// ----------------------------------------------------------------------------
module xcs_back (
	input  logic          clk,
	input  logic          arst_n,
	input  xcs_pkg::job_t head,
	input  logic          q_empty,
	output logic          pop,
	output logic          result_valid,
	input  logic          result_stall,
	output logic          send,
	output logic [7:0]    tx_byte,
	output logic [7:0]    run_length,
	output logic [1:0]    status,
	output logic [7:0]    block_number,
	output logic          last
);
	import xcs_pkg::*;

	logic [RES_IDX_W-1:0] idx_q;
	logic                 valid_q;
	res_t                 res_q;
	status_t              status_q;
	logic [7:0]           block_q;
	logic                 last_q;
	logic                 load, take, is_last;

	assign load    = !valid_q || !result_stall;
	assign take    = load && !q_empty;
	assign is_last = (idx_q == head.last_idx);
	assign pop     = take && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (take) begin
			valid_q <= 1'b1;
			idx_q   <= is_last ? '0 : idx_q + 1'b1;
		end else if (load) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q    <= head.res[idx_q];
			status_q <= head.status;
			block_q  <= head.block_number;
			last_q   <= is_last;
		end
	end

	assign result_valid = valid_q;
	assign send         = res_q.send;
	assign tx_byte      = res_q.tx_byte;
	assign run_length   = res_q.run_length;
	assign status       = status_q;
	assign block_number = block_q;
	assign last         = last_q;

endmodule

>>> sv/xmodem_checksum_sender.sv
// ----------------------------------------------------------------------------
// xmodem_checksum_sender
// XMODEM checksum-mode packet framer with decoupled protocol and output sides.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  item     | item_valid / item_stall    | op, value
//  result   | result_valid / result_stall| send, tx_byte, run_length, status,
//           |                            | block_number, last
//
// The front end takes one item a cycle while the job queue has room; the
// protocol state moves on at the edge the item is taken.
// Each item gives one to four result words (four for the first data byte of
// a packet); the back end sends one word a cycle while result_stall is low.
// Result stall holds the output register; the two-entry queue keeps taking
// items until it fills, then item_stall rises.
// Reset (arst_n low) clears the phase, block counter (to 1), fill count,
// checksum, pending-EOT flag, queue pointers and output valid. No sweep.
//
module xmodem_checksum_sender (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [1:0] op,
	input  logic [7:0] value,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       send,
	output logic [7:0] tx_byte,
	output logic [7:0] run_length,
	output logic [1:0] status,
	output logic [7:0] block_number,
	output logic       last
);
	import xcs_pkg::*;

	job_t job_in, job_head;
	logic job_push, job_pop, q_empty, q_full;

	// protocol front end: classifies the word and builds its job
	xcs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.op         (op),
		.value      (value),
		.job        (job_in),
		.job_push   (job_push),
		.q_full     (q_full)
	);

	// decoupling queue
	xcs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.wr_data (job_in),
		.pop     (job_pop),
		.rd_data (job_head),
		.empty   (q_empty),
		.full    (q_full)
	);

	// result sequencer and output register
	xcs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (job_head),
		.q_empty      (q_empty),
		.pop          (job_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.send         (send),
		.tx_byte      (tx_byte),
		.run_length   (run_length),
		.status       (status),
		.block_number (block_number),
		.last         (last)
	);

endmodule

>>> sv/xcs_checker.sv
// ----------------------------------------------------------------------------
// xcs_checker
// Port-level checks on the sender's result stream.
// ----------------------------------------------------------------------------
module xcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_stall,
	input logic [1:0] op,
	input logic [7:0] value,
	input logic       result_valid,
	input logic       result_stall,
	input logic       send,
	input logic [7:0] tx_byte,
	input logic [7:0] run_length,
	input logic [1:0] status,
	input logic [7:0] block_number,
	input logic       last
);
	import xcs_pkg::*;

	// a stalled input word stays offered and unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(op) && $stable(value))
		else $error("input word changed while stalled");

	// a held result word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	// a bare status word carries no bytes
	a_bare: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !send |-> (run_length == 8'd0) && (tx_byte == 8'd0))
		else $error("bare result carries a byte run");

	// a transmitted run is never empty
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && send |-> (run_length != 8'd0))
		else $error("empty run sent");

	// refused or aborted words are single bare results
	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && ((status == ST_REFUSED) || (status == ST_ABORTED))
		|-> !send && last)
		else $error("refused or aborted word produced link bytes");

endmodule

bind xmodem_checksum_sender xcs_checker u_checker (.*);
